// File: src/spf_pkg.sv
`default_nettype none

package spf_pkg;

  localparam int unsigned PacketBytesDef = 30;
  localparam int unsigned HdrLen         = 8;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;

  localparam logic [CfgIdxW-1:0] CfgSiteId    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSessionId = CfgIdxW'(1);

  localparam logic [15:0] Magic     = 16'h5359;
  localparam logic [7:0]  KindTime  = 8'h01;
  localparam logic [7:0]  KindFrame = 8'h02;
  localparam logic [7:0]  LenTime   = 8'd8;
  localparam logic [7:0]  LenFrame  = 8'd4;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [31:0] LcgMul    = 32'd1664525;
  localparam logic [31:0] LcgAdd    = 32'd1013904223;
  localparam logic [31:0] LcgSeed   = 32'h4A3B2C1D;

  typedef struct packed {
    logic        req_type;
    logic [63:0] payload_value;
    logic [31:0] tick_sample;
  } spf_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } spf_out_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/sync_packet_framer_crc16.sv
// a request transfer leads through the prep state to the first byte in the output register
// packets of PACKET_BYTES bytes do not overlap; header and payload leave from a shift register
// bytes leave one per cycle unless stalled, bounded by the single output register
// a new request is taken once the final crc byte has entered the output register
// reset: sequence number 0, pad generator 0x4A3B2C1D, site and session id 0, output empty
`default_nettype none

module sync_packet_framer_crc16 #(
  parameter int unsigned PACKET_BYTES = spf_pkg::PacketBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire spf_pkg::spf_req_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output spf_pkg::spf_out_t                  out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [spf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [spf_pkg::CfgDataW-1:0]  cfg_data_i
);

  import spf_pkg::*;

  localparam int unsigned CntW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned SrW  = 128;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StPrep = 3'b010,
    StSend = 3'b100
  } spf_state_e;

  spf_state_e  st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] site_q, site_d;
  logic [7:0]  session_q, session_d;
  logic [31:0] gen_q, gen_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;

  logic [SrW-1:0] sr_q, sr_d;
  logic [31:0] nxt_q, nxt_d;
  logic [31:0] tick_q, tick_d;
  logic        frame_q, frame_d;
  spf_out_t    out_q, out_d;

  logic        in_xfer;
  logic        load;
  logic [31:0] lcg_src;
  logic [31:0] lcg_step;
  logic [CntW-1:0] pay_end;
  logic [7:0]  byte_sel;
  logic        last_sel;
  logic [63:0] pay_word;

  assign in_stall_o  = (st_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign load        = (st_q == StSend) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lcg_src  = (st_q == StPrep) ? gen_q : nxt_q;
  assign lcg_step = 32'(lcg_src * LcgMul + LcgAdd + tick_q);
  assign pay_end  = frame_q ? CntW'(HdrLen + 4) : CntW'(HdrLen + 8);
  assign pay_word = in_data_i.req_type ? {in_data_i.payload_value[31:0], 32'h0}
                                       : in_data_i.payload_value;

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    seq_d       = seq_q;
    site_d      = site_q;
    session_d   = session_q;
    gen_d       = gen_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    sr_d        = sr_q;
    nxt_d       = nxt_q;
    tick_d      = tick_q;
    frame_d     = frame_q;
    out_d       = out_q;
    byte_sel    = crc_q[7:0];
    last_sel    = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSiteId:    site_d    = cfg_data_i;
        CfgSessionId: session_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      StIdle: begin
        if (in_xfer) begin
          frame_d = in_data_i.req_type;
          tick_d  = in_data_i.tick_sample;
          sr_d    = {Magic,
                     in_data_i.req_type ? KindFrame : KindTime,
                     in_data_i.req_type ? LenFrame : LenTime,
                     site_q, seq_q, session_q, pay_word};
          seq_d   = seq_q + 8'd1;
          st_d    = StPrep;
        end
      end
      StPrep: begin
        nxt_d = lcg_step;
        crc_d = CrcInit;
        cnt_d = '0;
        st_d  = StSend;
      end
      StSend: begin
        if (cnt_q < pay_end) begin
          byte_sel = sr_q[SrW-1 -: 8];
        end else if (cnt_q < CntW'(PACKET_BYTES - 2)) begin
          byte_sel = nxt_q[31:24];
        end else if (cnt_q == CntW'(PACKET_BYTES - 2)) begin
          byte_sel = crc_q[15:8];
        end else begin
          byte_sel = crc_q[7:0];
          last_sel = 1'b1;
        end
        if (load) begin
          out_valid_d        = 1'b1;
          out_d.out_byte     = byte_sel;
          out_d.last_byte    = last_sel;
          cnt_d              = cnt_q + CntW'(1);
          if (cnt_q < pay_end) begin
            sr_d = {sr_q[SrW-9:0], 8'h00};
          end else if (cnt_q < CntW'(PACKET_BYTES - 2)) begin
            gen_d = nxt_q;
            nxt_d = lcg_step;
          end
          if (cnt_q < CntW'(PACKET_BYTES - 2)) begin
            crc_d = crc_byte(crc_q, byte_sel);
          end
          if (last_sel) begin
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      cnt_q       <= '0;
      seq_q       <= '0;
      site_q      <= '0;
      session_q   <= '0;
      gen_q       <= LcgSeed;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      seq_q       <= seq_d;
      site_q      <= site_d;
      session_q   <= session_d;
      gen_q       <= gen_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q    <= sr_d;
    nxt_q   <= nxt_d;
    tick_q  <= tick_d;
    frame_q <= frame_d;
    out_q   <= out_d;
  end

  a_xfer_prep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (st_q == StPrep))
    else $error("request transfer did not start a packet");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_sel) |=> (st_q == StIdle) && out_valid_q && out_q.last_byte)
    else $error("final byte did not end the packet");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSend) |-> (cnt_q < CntW'(PACKET_BYTES)))
    else $error("byte counter out of range");

  a_seq_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != $past(seq_q)) |-> $past(in_xfer))
    else $error("sequence number moved without a request");

  a_gen_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StSend) |=> $stable(gen_q))
    else $error("pad generator moved outside a packet");

endmodule

`default_nettype wire

// File: bench/sync_packet_framer_crc16_test.sv
`default_nettype none

module sync_packet_framer_crc16_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  localparam int FrameLen = PacketBytesDef;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpare3 = CfgIdxW'(3);
  localparam int RandPhases = 5;
  localparam int PhaseItems = 82;
  localparam int HoldCycles = 400;

  typedef enum logic {StepReq, StepCfg} step_kind_e;

  typedef struct packed {
    step_kind_e         kind;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        wdata;
    logic               req_type;
    logic [63:0]        value;
    logic [31:0]        tick;
    logic               hdr_known;
    logic [63:0]        hdr;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  spf_req_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  spf_out_t  out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state
  logic [15:0] site_reg = '0;
  logic [7:0]  session_reg = '0;
  logic [7:0]  seq_no = '0;
  logic [31:0] pad_lcg = LcgSeed;
  spf_out_t    packet_bytes_due[$];

  plan_row_t plan[$];
  bit steady_run = 1'b0;
  bit hold_ask = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int bytes_checked = 0;
  int n_time = 0;
  int n_frame = 0;
  int cfg_writes = 0;

  sync_packet_framer_crc16 u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic void frame_packet(spf_req_t req, logic hdr_known, logic [63:0] hdr);
    logic [7:0]  pkt [FrameLen];
    logic [15:0] crc;
    logic        fb;
    int          plen;
    plen = req.req_type ? 4 : 8;
    pkt[0] = Magic[15:8];
    pkt[1] = Magic[7:0];
    pkt[2] = req.req_type ? KindFrame : KindTime;
    pkt[3] = req.req_type ? LenFrame : LenTime;
    pkt[4] = site_reg[15:8];
    pkt[5] = site_reg[7:0];
    pkt[6] = seq_no;
    pkt[7] = session_reg;
    seq_no = seq_no + 8'd1;
    if (hdr_known) begin
      for (int i = 0; i < HdrLen; i++) pkt[i] = hdr[63-8*i -: 8];
    end
    for (int i = 0; i < plen; i++) pkt[HdrLen+i] = req.payload_value[8*(plen-1-i) +: 8];
    for (int i = HdrLen + plen; i < FrameLen - 2; i++) begin
      pad_lcg = pad_lcg * LcgMul + LcgAdd + req.tick_sample;
      pkt[i] = pad_lcg[31:24];
    end
    crc = CrcInit;
    for (int i = 0; i < FrameLen - 2; i++) begin
      for (int b = 7; b >= 0; b--) begin
        fb = crc[15] ^ pkt[i][b];
        crc = {crc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
      end
    end
    pkt[FrameLen-2] = crc[15:8];
    pkt[FrameLen-1] = crc[7:0];
    for (int i = 0; i < FrameLen; i++) begin
      packet_bytes_due.push_back('{out_byte: pkt[i], last_byte: (i == FrameLen - 1)});
    end
    if (req.req_type) n_frame++;
    else n_time++;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic spf_req_t random_req();
    spf_req_t r;
    r.req_type      = 1'($urandom_range(1));
    r.payload_value = {pick_word(), pick_word()};
    r.tick_sample   = pick_word();
    return r;
  endfunction

  function automatic logic [15:0] pick_cfg();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic void flag_mismatch(string what, int idx, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s at byte %0d: expected %02h, got %02h", what, idx, want, got);
    end
  endfunction

  // all tasks are entered and left at a falling edge
  task automatic send_req(spf_req_t req, logic hdr_known, logic [63:0] hdr);
    while (!steady_run && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
    frame_packet(req, hdr_known, hdr);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CfgSiteId) site_reg = value;
    else if (idx == CfgSessionId) session_reg = value[7:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (packet_bytes_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // receiver: random stalls (none in the steady phase), plus one long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_ask) begin
      hold_left = HoldCycles;
      hold_ask  = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (steady_run) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 15);
    end
  end

  // output transfer check
  always @(posedge clk_i) begin : check_out
    spf_out_t due;
    if (rst_ni && out_valid && !out_stall) begin
      if (packet_bytes_due.size() == 0) begin
        flag_mismatch("unexpected", bytes_checked, 8'h00, out_data.out_byte);
      end else begin
        due = packet_bytes_due.pop_front();
        if (out_data.out_byte !== due.out_byte) begin
          flag_mismatch("out_byte", bytes_checked, due.out_byte, out_data.out_byte);
        end
        if (out_data.last_byte !== due.last_byte) begin
          flag_mismatch("last_byte", bytes_checked, 8'(due.last_byte), 8'(out_data.last_byte));
        end
      end
      bytes_checked++;
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d bytes outstanding", packet_bytes_due.size());
    $display("sync_packet_framer_crc16_test: errors");
    $finish;
  end

  initial begin
    plan_row_t row;
    // kind, index, data, req_type, value, tick, header known, header
    plan.push_back('{StepReq, '0, '0, 1'b0, 64'h0, 32'h0, 1'b1, 64'h5359_0108_0000_0000});
    plan.push_back('{StepReq, '0, '0, 1'b1, '1, '1, 1'b1, 64'h5359_0204_0000_0100});
    plan.push_back('{StepReq, '0, '0, 1'b1, 64'hDEAD_BEEF_1234_5678, 32'h1, 1'b0, '0});
    plan.push_back('{StepReq, '0, '0, 1'b0, 64'h0123_4567_89AB_CDEF, 32'h8000_0000, 1'b0, '0});
    plan.push_back('{StepCfg, CfgSiteId, 16'hFFFF, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepCfg, CfgSessionId, 16'hFFFF, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepReq, '0, '0, 1'b0, '1, '1, 1'b1, 64'h5359_0108_FFFF_04FF});
    plan.push_back('{StepReq, '0, '0, 1'b1, 64'h0, 32'h0, 1'b1, 64'h5359_0204_FFFF_05FF});
    plan.push_back('{StepCfg, CfgSpare2, 16'h1234, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepCfg, CfgSpare3, 16'hABCD, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepReq, '0, '0, 1'b0, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 1'b1,
                     64'h5359_0108_FFFF_06FF});
    plan.push_back('{StepCfg, CfgSiteId, 16'h8001, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepCfg, CfgSessionId, 16'h0100, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepReq, '0, '0, 1'b1, 64'h0000_0000_8000_0001, 32'h5555_5555, 1'b1,
                     64'h5359_0204_8001_0700});
    plan.push_back('{StepReq, '0, '0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '0});
    plan.push_back('{StepCfg, CfgSiteId, 16'h0000, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepCfg, CfgSessionId, 16'h0000, 1'b0, '0, '0, 1'b0, '0});
    plan.push_back('{StepReq, '0, '0, 1'b1, 64'h5555_5555_5555_5555, 32'h0000_FFFF, 1'b0, '0});

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == StepCfg) begin
        settle();
        write_reg(row.idx, row.wdata);
      end else begin
        send_req('{req_type: row.req_type, payload_value: row.value, tick_sample: row.tick},
                 row.hdr_known, row.hdr);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      settle();
      write_reg(CfgSiteId, pick_cfg());
      write_reg(CfgSessionId, pick_cfg());
      if ($urandom_range(1) == 1) begin
        write_reg($urandom_range(1) == 1 ? CfgSpare2 : CfgSpare3, 16'($urandom_range(65535)));
      end
      steady_run = (p == 1);
      if (p == 2) begin
        @(posedge clk_i);
        hold_ask = 1'b1;
        @(negedge clk_i);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // in phase 3 the sender waits mid-phase for every byte of the earlier packets
        if (p == 3 && n == PhaseItems / 2) settle();
        send_req(random_req(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (packet_bytes_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("sent %0d time and %0d frame packets, %0d bytes checked, %0d register writes",
             n_time, n_frame, bytes_checked, cfg_writes);
    $display("sequence number wrapped past 255, long output hold-off and drain pauses included");
    if (mismatches == 0) begin
      $display("sync_packet_framer_crc16_test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("sync_packet_framer_crc16_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
